[src/afsc_pkg.sv]
// Shared types, field codes and rate tables for the MPEG audio frame size calculator.
package afsc_pkg;

  localparam int HDR_W   = 32;
  localparam int KBPS_W  = 9;
  localparam int MULT_W  = 18;
  localparam int NUM_W   = 26;
  localparam int RECIP_W = 13;
  localparam int FREQ_W  = 16;
  localparam int Q0_W    = 13;
  localparam int QUOT_W  = 12;
  localparam int REM_W   = 17;
  localparam int SIDE_W  = 6;
  localparam int DATA_W  = 13;
  localparam int FCODE_W = 3;
  localparam int RECIP_SHIFT = 26;

  localparam logic [1:0] LM_RESERVED = 2'b00;
  localparam logic [1:0] LM_LAYER3   = 2'b01;
  localparam logic [1:0] LM_LAYER2   = 2'b10;
  localparam logic [1:0] LM_LAYER1   = 2'b11;

  localparam logic [1:0] VER_ONE = 2'b11;
  localparam logic [1:0] VER_TWO = 2'b10;

  localparam logic [1:0] RIDX_RESERVED  = 2'b11;
  localparam logic [1:0] MODE_SINGLE_CH = 2'b11;

  localparam logic [FCODE_W-1:0] FC_V1_BASE = 3'd0;
  localparam logic [FCODE_W-1:0] FC_V2_BASE = 3'd3;
  localparam logic [FCODE_W-1:0] FC_V25     = 3'd6;

  localparam logic [MULT_W-1:0] K_LAYER1  = 18'd12000;
  localparam logic [MULT_W-1:0] K_SPF1152 = 18'd144000;
  localparam logic [MULT_W-1:0] K_SPF576  = 18'd72000;

  localparam logic [SIDE_W-1:0] SIDE_V1_MONO   = 6'd17;
  localparam logic [SIDE_W-1:0] SIDE_V1_STEREO = 6'd32;
  localparam logic [SIDE_W-1:0] SIDE_V2_MONO   = 6'd9;
  localparam logic [SIDE_W-1:0] SIDE_V2_STEREO = 6'd17;
  localparam logic [SIDE_W-1:0] SIDE_CRC       = 6'd2;

  localparam logic [FREQ_W-1:0] FREQ_TAB [8] = '{
    16'd44100, 16'd48000, 16'd32000, 16'd22050,
    16'd24000, 16'd16000, 16'd11025, 16'd11025
  };

  // floor(2^26 / freq)
  localparam logic [RECIP_W-1:0] RECIP_TAB [8] = '{
    13'd1521, 13'd1398, 13'd2097, 13'd3043,
    13'd2796, 13'd4194, 13'd6086, 13'd6086
  };

  localparam logic [KBPS_W-1:0] KBPS_V1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0
  };

  localparam logic [KBPS_W-1:0] KBPS_V1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0
  };

  localparam logic [KBPS_W-1:0] KBPS_V1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
  };

  localparam logic [KBPS_W-1:0] KBPS_V2_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0
  };

  localparam logic [KBPS_W-1:0] KBPS_V2_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
  };

  typedef struct packed {
    logic              ok;
    logic              layer1;
    logic              pad;
    logic [SIDE_W-1:0] side;
  } afsc_side_t;

endpackage

[src/afsc_div.sv]
// Three-stage frame length divider: numerator product, reciprocal quotient, remainder fix-up.
module afsc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [afsc_pkg::KBPS_W-1:0]      in_kbps,
  input  logic [afsc_pkg::MULT_W-1:0]      in_mult,
  input  logic [afsc_pkg::FCODE_W-1:0]     in_fcode,
  input  afsc_pkg::afsc_side_t             in_side,
  output logic                             out_valid,
  output logic [afsc_pkg::QUOT_W-1:0]      out_quot,
  output afsc_pkg::afsc_side_t             out_side
);

  localparam int ProdAW = afsc_pkg::KBPS_W + afsc_pkg::MULT_W;
  localparam int ProdBW = afsc_pkg::NUM_W + afsc_pkg::RECIP_W;
  localparam int ProdCW = afsc_pkg::Q0_W + afsc_pkg::FREQ_W;

  logic                            a_valid_r, a_valid_nxt;
  logic [afsc_pkg::NUM_W-1:0]      a_num_r, a_num_nxt;
  logic [afsc_pkg::FCODE_W-1:0]    a_fcode_r;
  afsc_pkg::afsc_side_t            a_side_r;

  logic                            b_valid_r;
  logic [afsc_pkg::NUM_W-1:0]      b_num_r;
  logic [afsc_pkg::Q0_W-1:0]       b_q0_r, b_q0_nxt;
  logic [afsc_pkg::FCODE_W-1:0]    b_fcode_r;
  afsc_pkg::afsc_side_t            b_side_r;

  logic                            c_valid_r;
  logic [afsc_pkg::Q0_W-1:0]       c_q0_r;
  logic                            c_corr_r, c_corr_nxt;
  afsc_pkg::afsc_side_t            c_side_r;

  logic [ProdAW-1:0]               prod_a;
  logic [ProdBW-1:0]               prod_b;
  logic [ProdCW-1:0]               prod_c;
  logic [afsc_pkg::FREQ_W-1:0]     c_freq;
  logic [afsc_pkg::NUM_W-1:0]      diff;
  logic [afsc_pkg::REM_W-1:0]      rem;
  logic [afsc_pkg::Q0_W-1:0]       quot_sum;

  always_comb begin
    a_valid_nxt = in_valid;
    prod_a      = ProdAW'(in_kbps) * ProdAW'(in_mult);
    a_num_nxt   = prod_a[afsc_pkg::NUM_W-1:0];
  end

  always_comb begin
    prod_b   = ProdBW'(a_num_r) * ProdBW'(afsc_pkg::RECIP_TAB[a_fcode_r]);
    b_q0_nxt = prod_b[ProdBW-1:afsc_pkg::RECIP_SHIFT];
  end

  always_comb begin
    c_freq     = afsc_pkg::FREQ_TAB[b_fcode_r];
    prod_c     = ProdCW'(b_q0_r) * ProdCW'(c_freq);
    diff       = b_num_r - prod_c[afsc_pkg::NUM_W-1:0];
    rem        = diff[afsc_pkg::REM_W-1:0];
    c_corr_nxt = (rem >= afsc_pkg::REM_W'(c_freq));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num_r   <= a_num_nxt;
      a_fcode_r <= in_fcode;
      a_side_r  <= in_side;
      b_num_r   <= a_num_r;
      b_q0_r    <= b_q0_nxt;
      b_fcode_r <= a_fcode_r;
      b_side_r  <= a_side_r;
      c_q0_r    <= b_q0_r;
      c_corr_r  <= c_corr_nxt;
      c_side_r  <= b_side_r;
    end
  end

  assign quot_sum  = c_q0_r + afsc_pkg::Q0_W'(c_corr_r);
  assign out_valid = c_valid_r;
  assign out_quot  = quot_sum[afsc_pkg::QUOT_W-1:0];
  assign out_side  = c_side_r;

endmodule

[src/audio_frame_size_calc_core.sv]
// Top level of the MPEG audio frame size calculator.
//
// Input channel: in_valid / in_stall with in_header_word, one 32-bit frame header per transfer.
// Result channel: out_valid / out_stall with out_header_ok, out_side_info_bytes and
// out_main_data_bytes (two's complement), one result per header, in order.
// A rejected header (no sync, rate index 3, reserved layer) gives ok low and zero sizes.
// Throughput: one header per cycle unless a shown result is stalled. Registers from the input
// transfer to the result on the output register: decode, numerator product, reciprocal quotient,
// remainder fix-up, size assembly; the divide by the sample rate sets the depth.
// Reset (rst_n low, synchronous) empties every stage; no result is shown afterwards
// until a new header arrives.
// While the receiver stalls a shown result, the whole pipeline holds and in_stall is
// raised in the same cycle; nothing is lost or repeated and the result stays put.
module audio_frame_size_calc_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [afsc_pkg::HDR_W-1:0]         in_header_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_header_ok,
  output logic [afsc_pkg::SIDE_W-1:0]        out_side_info_bytes,
  output logic signed [afsc_pkg::DATA_W-1:0] out_main_data_bytes
);

  logic                               en;
  logic [1:0]                         ridx, lm, ver, mode;
  logic [3:0]                         bidx;
  logic                               grp2;

  logic                               s1_valid_r;
  logic [afsc_pkg::KBPS_W-1:0]        s1_kbps_r, s1_kbps_nxt;
  logic [afsc_pkg::MULT_W-1:0]        s1_mult_r, s1_mult_nxt;
  logic [afsc_pkg::FCODE_W-1:0]       s1_fcode_r, s1_fcode_nxt;
  afsc_pkg::afsc_side_t               s1_side_r, s1_side_nxt;

  logic                               dv_valid;
  logic [afsc_pkg::QUOT_W-1:0]        dv_quot;
  afsc_pkg::afsc_side_t               dv_side;

  logic [afsc_pkg::QUOT_W-1:0]        frame_base;
  logic [afsc_pkg::DATA_W-1:0]        pad_amt;
  logic [afsc_pkg::DATA_W-1:0]        data_calc;

  logic                               out_valid_r;
  logic                               out_ok_r, out_ok_nxt;
  logic [afsc_pkg::SIDE_W-1:0]        out_side_r, out_side_nxt;
  logic [afsc_pkg::DATA_W-1:0]        out_data_r, out_data_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign ridx = in_header_word[11:10];
  assign lm   = in_header_word[18:17];
  assign ver  = in_header_word[20:19];
  assign mode = in_header_word[7:6];
  assign bidx = in_header_word[15:12];
  assign grp2 = (ver != afsc_pkg::VER_ONE);

  always_comb begin
    s1_side_nxt.ok     = (&in_header_word[31:21]) && (ridx != afsc_pkg::RIDX_RESERVED)
                         && (lm != afsc_pkg::LM_RESERVED);
    s1_side_nxt.layer1 = (lm == afsc_pkg::LM_LAYER1);
    s1_side_nxt.pad    = in_header_word[9];
    s1_side_nxt.side   = '0;

    if (ver == afsc_pkg::VER_ONE) begin
      s1_fcode_nxt = afsc_pkg::FC_V1_BASE + afsc_pkg::FCODE_W'(ridx);
    end else if (ver == afsc_pkg::VER_TWO) begin
      s1_fcode_nxt = afsc_pkg::FC_V2_BASE + afsc_pkg::FCODE_W'(ridx);
    end else begin
      s1_fcode_nxt = afsc_pkg::FC_V25;
    end

    unique case (lm)
      afsc_pkg::LM_LAYER1: begin
        s1_kbps_nxt = grp2 ? afsc_pkg::KBPS_V2_L1[bidx] : afsc_pkg::KBPS_V1_L1[bidx];
        s1_mult_nxt = afsc_pkg::K_LAYER1;
      end
      afsc_pkg::LM_LAYER2: begin
        s1_kbps_nxt = grp2 ? afsc_pkg::KBPS_V2_L23[bidx] : afsc_pkg::KBPS_V1_L2[bidx];
        s1_mult_nxt = afsc_pkg::K_SPF1152;
      end
      afsc_pkg::LM_LAYER3: begin
        s1_kbps_nxt = grp2 ? afsc_pkg::KBPS_V2_L23[bidx] : afsc_pkg::KBPS_V1_L3[bidx];
        s1_mult_nxt = grp2 ? afsc_pkg::K_SPF576 : afsc_pkg::K_SPF1152;
        if (grp2) begin
          s1_side_nxt.side = (mode == afsc_pkg::MODE_SINGLE_CH) ? afsc_pkg::SIDE_V2_MONO
                                                                : afsc_pkg::SIDE_V2_STEREO;
        end else begin
          s1_side_nxt.side = (mode == afsc_pkg::MODE_SINGLE_CH) ? afsc_pkg::SIDE_V1_MONO
                                                                : afsc_pkg::SIDE_V1_STEREO;
        end
        if (!in_header_word[16]) begin
          s1_side_nxt.side = s1_side_nxt.side + afsc_pkg::SIDE_CRC;
        end
      end
      default: begin
        s1_kbps_nxt = '0;
        s1_mult_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kbps_r  <= s1_kbps_nxt;
      s1_mult_r  <= s1_mult_nxt;
      s1_fcode_r <= s1_fcode_nxt;
      s1_side_r  <= s1_side_nxt;
    end
  end

  afsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_valid_r),
    .in_kbps   (s1_kbps_r),
    .in_mult   (s1_mult_r),
    .in_fcode  (s1_fcode_r),
    .in_side   (s1_side_r),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  always_comb begin
    frame_base = dv_side.layer1 ? {dv_quot[afsc_pkg::QUOT_W-3:0], 2'b00} : dv_quot;
    if (!dv_side.pad) begin
      pad_amt = '0;
    end else if (dv_side.layer1) begin
      pad_amt = afsc_pkg::DATA_W'(4);
    end else begin
      pad_amt = afsc_pkg::DATA_W'(1);
    end
    data_calc = afsc_pkg::DATA_W'(frame_base) + pad_amt
                - afsc_pkg::DATA_W'(dv_side.side) - afsc_pkg::DATA_W'(4);
    out_ok_nxt   = dv_side.ok;
    out_side_nxt = dv_side.ok ? dv_side.side : '0;
    out_data_nxt = dv_side.ok ? data_calc : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ok_r   <= out_ok_nxt;
      out_side_r <= out_side_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_header_ok       = out_ok_r;
  assign out_side_info_bytes = out_side_r;
  assign out_main_data_bytes = out_data_r;

endmodule

[src/afsc_checker.sv]
// Port-level checker for the frame size calculator and its bind to the top level.
module afsc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_header_ok,
  input logic [afsc_pkg::SIDE_W-1:0]        out_side_info_bytes,
  input logic signed [afsc_pkg::DATA_W-1:0] out_main_data_bytes
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_main_data_bytes) && $stable(out_side_info_bytes)
      && $stable(out_header_ok))
    else $error("stalled result changed");

  a_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_header_ok |-> out_side_info_bytes == '0 && out_main_data_bytes == '0)
    else $error("rejected header with non-zero sizes");

  a_side_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_side_info_bytes == 6'd0 || out_side_info_bytes == 6'd9
      || out_side_info_bytes == 6'd11 || out_side_info_bytes == 6'd17
      || out_side_info_bytes == 6'd19 || out_side_info_bytes == 6'd32
      || out_side_info_bytes == 6'd34)
    else $error("impossible side information size");

endmodule

bind audio_frame_size_calc_core afsc_checker u_afsc_checker (.*);

[verif/audio_frame_size_calc_core_tb.sv]
// Self-checking testbench for the MPEG audio frame size calculator core.
`timescale 1ns / 100ps

module audio_frame_size_calc_core_tb;

  localparam int DIR_ROWS    = 25;
  localparam int RAND_ITEMS  = 1000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic                               ok;
    logic [afsc_pkg::SIDE_W-1:0]        side;
    logic signed [afsc_pkg::DATA_W-1:0] data;
  } frame_sizes_t;

  typedef struct packed {
    logic [afsc_pkg::HDR_W-1:0] hdr;
    logic                       typed_in;
    frame_sizes_t               want;
  } hdr_row_t;

  logic                               clk;
  logic                               rst_n          = 1'b0;
  logic                               in_valid       = 1'b0;
  logic                               in_stall;
  logic [afsc_pkg::HDR_W-1:0]         in_header_word = '0;
  logic                               out_valid;
  logic                               out_stall      = 1'b0;
  logic                               out_header_ok;
  logic [afsc_pkg::SIDE_W-1:0]        out_side_info_bytes;
  logic signed [afsc_pkg::DATA_W-1:0] out_main_data_bytes;

  frame_sizes_t expected_sizes[$];
  int           mismatches = 0;
  int           cycles     = 0;
  bit           quiet_in   = 1'b0;
  bit           quiet_out  = 1'b0;

  hdr_row_t directed_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'hFFE0_0000, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'h7FFB_9064, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'hFFDB_9064, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'hFFFB_9C64, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'hFFF9_9064, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'hFFE5_EE00, 1'b1, '{1'b0, 6'd0,  13'sd0}},
    '{32'hFFFA_F000, 1'b1, '{1'b1, 6'd34, -13'sd38}},
    '{32'hFFFC_0000, 1'b1, '{1'b1, 6'd0,  -13'sd4}},
    '{32'hFFE5_E200, 1'b1, '{1'b1, 6'd0,  13'sd2086}},
    '{32'hFFFB_9064, 1'b0, '0},
    '{32'hFFFB_90C4, 1'b0, '0},
    '{32'hFFFA_9264, 1'b0, '0},
    '{32'hFFF3_9864, 1'b0, '0},
    '{32'hFFF2_E4C0, 1'b0, '0},
    '{32'hFFEB_E0C0, 1'b0, '0},
    '{32'hFFE3_E800, 1'b0, '0},
    '{32'hFFFF_E200, 1'b0, '0},
    '{32'hFFFF_EA00, 1'b0, '0},
    '{32'hFFFE_1000, 1'b0, '0},
    '{32'hFFF7_C400, 1'b0, '0},
    '{32'hFFE7_E200, 1'b0, '0},
    '{32'hFFF5_B800, 1'b0, '0},
    '{32'hFFFD_EA00, 1'b0, '0}
  };

  audio_frame_size_calc_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_header_word      (in_header_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_header_ok       (out_header_ok),
    .out_side_info_bytes (out_side_info_bytes),
    .out_main_data_bytes (out_main_data_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int kbps_of(input bit v1, input logic [1:0] lm, input logic [3:0] bidx);
    int tab [16];
    if (v1 && lm == afsc_pkg::LM_LAYER1)
      tab = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0};
    else if (v1 && lm == afsc_pkg::LM_LAYER2)
      tab = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0};
    else if (v1)
      tab = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
    else if (lm == afsc_pkg::LM_LAYER1)
      tab = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
    else
      tab = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
    return tab[bidx];
  endfunction

  function automatic frame_sizes_t frame_sizes(input logic [afsc_pkg::HDR_W-1:0] hdr);
    logic [1:0]   ver;
    logic [1:0]   lm;
    logic [1:0]   ridx;
    bit           v1;
    bit           mono;
    int           freq;
    int           kbps;
    int           side;
    int           bytes;
    frame_sizes_t r;
    ver  = hdr[20:19];
    lm   = hdr[18:17];
    ridx = hdr[11:10];
    r    = '0;
    if (hdr[31:21] != 11'h7FF || ridx == afsc_pkg::RIDX_RESERVED
        || lm == afsc_pkg::LM_RESERVED)
      return r;
    v1   = (ver == afsc_pkg::VER_ONE);
    mono = (hdr[7:6] == afsc_pkg::MODE_SINGLE_CH);
    if (ver == afsc_pkg::VER_ONE)
      freq = (ridx == 2'd0) ? 44100 : (ridx == 2'd1) ? 48000 : 32000;
    else if (ver == afsc_pkg::VER_TWO)
      freq = (ridx == 2'd0) ? 22050 : (ridx == 2'd1) ? 24000 : 16000;
    else
      freq = 11025;
    kbps = kbps_of(v1, lm, hdr[15:12]);
    side = v1 ? (mono ? 17 : 32) : (mono ? 9 : 17);
    case (lm)
      afsc_pkg::LM_LAYER3: begin
        bytes = (kbps * 125 * (v1 ? 1152 : 576)) / freq + int'(hdr[9]);
        if (!hdr[16])
          side += 2;
      end
      afsc_pkg::LM_LAYER2: begin
        bytes = (kbps * 125 * 1152) / freq + int'(hdr[9]);
        side  = 0;
      end
      default: begin
        bytes = ((kbps * 125 * 384) / (freq * 4)) * 4 + 4 * int'(hdr[9]);
        side  = 0;
      end
    endcase
    r.ok   = 1'b1;
    r.side = side[afsc_pkg::SIDE_W-1:0];
    r.data = afsc_pkg::DATA_W'(bytes - side - 4);
    return r;
  endfunction

  function automatic logic [afsc_pkg::HDR_W-1:0] random_header();
    logic [afsc_pkg::HDR_W-1:0] h;
    h = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      h[31:21] = 11'h7FF;
      h[18:17] = 2'($urandom_range(1, 3));
      h[11:10] = 2'($urandom_range(0, 2));
    end
    return h;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_header(input logic [afsc_pkg::HDR_W-1:0] hdr, input frame_sizes_t want);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_header_word <= hdr;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_sizes.push_back(want);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_sizes.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [afsc_pkg::HDR_W-1:0] h;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      h = directed_rows[i].hdr;
      send_header(h, directed_rows[i].typed_in ? directed_rows[i].want : frame_sizes(h));
    end
    hold_until_drained();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0)
        quiet_in = ($urandom_range(0, 3) == 0);
      if (i == RAND_ITEMS / 2)
        hold_until_drained();
      h = random_header();
      send_header(h, frame_sizes(h));
    end
    in_valid <= 1'b0;
    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n;
    int taken;
    taken = 0;
    forever begin
      if (taken % 100 == 0)
        quiet_out = ($urandom_range(0, 3) == 0);
      n = quiet_out ? 0 : $urandom_range(0, 16);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  always @(posedge clk) begin : check_results
    frame_sizes_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_sizes.size() == 0) begin
        report_mismatch("result transfer with no header outstanding");
      end else begin
        want = expected_sizes.pop_front();
        if (out_header_ok !== want.ok)
          report_mismatch($sformatf("header_ok %b, want %b", out_header_ok, want.ok));
        if (out_side_info_bytes !== want.side)
          report_mismatch($sformatf("side_info_bytes %0d, want %0d",
                                    out_side_info_bytes, want.side));
        if (out_main_data_bytes !== want.data)
          report_mismatch($sformatf("main_data_bytes %0d, want %0d",
                                    out_main_data_bytes, want.data));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

[files.f]
src/afsc_pkg.sv
src/afsc_div.sv
src/audio_frame_size_calc_core.sv
src/afsc_checker.sv
verif/audio_frame_size_calc_core_tb.sv
